// ----- rtl/bloom_filter_two_hash_top_macros.svh -----
// Assertion macros shared by the bloom filter RTL.
`ifndef BLOOM_FILTER_TWO_HASH_TOP_MACROS_SVH
`define BLOOM_FILTER_TWO_HASH_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever the antecedent holds, the consequent holds.
`define BFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define BFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BFT_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/bft_pkg.sv -----
// Shared types and constants of the two-hash bloom filter.
`default_nettype none
package bft_pkg;

   localparam int ACC_W            = 32;
   localparam int BYTE_W           = 8;
   localparam int SIZE_W           = 8;
   localparam int SLOT_OUT_W       = 7;
   localparam int DIGIT_W          = 4;
   localparam int RED_STEPS        = ACC_W / DIGIT_W;
   localparam int RED_CNT_W        = $clog2(RED_STEPS);
   localparam int MAX_BITS_DEFAULT = 128;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd10;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_ACCUM  = 5'b00010,
      ST_REDUCE = 5'b00100,
      ST_LOOKUP = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic acc_en;
      logic red_step;
      logic lookup;
      logic finish;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/bft_mod_lane.sv -----
// One modulo reduction lane: folds a 32-bit value into a remainder a digit per cycle while step is high.
`default_nettype none
module bft_mod_lane (
   input  wire logic                             clock,
   input  wire logic                             init,
   input  wire logic                             step,
   input  wire logic [bft_pkg::DIGIT_W-1:0]      digit,
   input  wire logic [bft_pkg::SIZE_W-1:0]       modulus,
   output logic      [bft_pkg::SIZE_W-1:0]       rem
);

   logic [bft_pkg::SIZE_W-1:0] rem_ff;
   logic [bft_pkg::SIZE_W-1:0] rem_in;
   logic [bft_pkg::SIZE_W-1:0] folded;

   // Restoring reduction, one bit per inner step; the remainder stays below
   // the modulus, so a single conditional subtract keeps it in range.
   always_comb begin
      logic [bft_pkg::SIZE_W:0] trial;
      logic [bft_pkg::SIZE_W-1:0] r;
      r = rem_ff;
      for (int i = bft_pkg::DIGIT_W - 1; i >= 0; i--) begin
         trial = {r, digit[i]};
         if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
         end
         r = trial[bft_pkg::SIZE_W-1:0];
      end
      folded = r;
   end

   always_comb begin
      priority if (init) begin
         rem_in = '0;
      end else if (step) begin
         rem_in = folded;
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign rem = rem_ff;

endmodule
`default_nettype wire

// ----- rtl/bft_datapath.sv -----
// Datapath: size register, hash accumulators, reduction lanes, bit store, result register.
`default_nettype none
module bft_datapath #(
   parameter int MAX_BITS = bft_pkg::MAX_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bft_pkg::cmd_type                    cmd,
   output bft_pkg::status_type                      status,
   input  wire logic                                csr_write_enable,
   input  wire logic [bft_pkg::SIZE_W-1:0]          csr_write_data,
   input  wire logic                                req_func,
   input  wire logic [bft_pkg::BYTE_W-1:0]          req_key_byte,
   input  wire logic                                req_key_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_op_kind,
   output logic                                     rsp_may_exist,
   output logic      [bft_pkg::SLOT_OUT_W-1:0]      rsp_slot_a,
   output logic      [bft_pkg::SLOT_OUT_W-1:0]      rsp_slot_b
);

   localparam int SLOT_W = $clog2(MAX_BITS);
   localparam int ACC_W  = bft_pkg::ACC_W;
   localparam int SIZE_W = bft_pkg::SIZE_W;

   logic [SIZE_W-1:0] size_ff, size_in, size_eff;
   logic [ACC_W-1:0]  sum_ff, sum_in, prod_ff, prod_in;
   logic              func_ff, func_in;
   logic [SLOT_W-1:0] clr_addr_ff, clr_addr_in;
   logic [SIZE_W-1:0] rem_a, rem_b;
   logic              lane_init;
   logic [SLOT_W-1:0] addr_a, addr_b, wr_addr;
   logic              wr_en, wr_data;
   logic              rd_a_ff, rd_b_ff;
   logic              is_insert;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            op_ff, hit_ff;
   logic [bft_pkg::SLOT_OUT_W-1:0]  slot_a_ff, slot_b_ff;

   logic mem [MAX_BITS];

   // Size register and the size actually used as the modulus.
   assign size_in = csr_write_enable ? csr_write_data : size_ff;

   always_comb begin
      priority if (size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (32'(size_ff) > 32'(MAX_BITS)) begin
         size_eff = SIZE_W'(MAX_BITS);
      end else begin
         size_eff = size_ff;
      end
   end

   // Accumulators; during reduction they shift out their top digit each cycle.
   always_comb begin
      priority if (cmd.lookup) begin
         sum_in  = '0;
         prod_in = ACC_W'(1);
      end else if (cmd.acc_en) begin
         sum_in  = sum_ff + ACC_W'(req_key_byte);
         prod_in = ACC_W'(prod_ff * ACC_W'(req_key_byte));
      end else if (cmd.red_step) begin
         sum_in  = sum_ff << bft_pkg::DIGIT_W;
         prod_in = prod_ff << bft_pkg::DIGIT_W;
      end else begin
         sum_in  = sum_ff;
         prod_in = prod_ff;
      end
   end

   assign lane_init = cmd.acc_en & req_key_last;
   assign func_in   = lane_init ? req_func : func_ff;
   assign is_insert = (func_ff == bft_pkg::FUNC_INSERT);

   bft_mod_lane u_lane_a (
      .clock   (clock),
      .init    (lane_init),
      .step    (cmd.red_step),
      .digit   (sum_ff[ACC_W-1 -: bft_pkg::DIGIT_W]),
      .modulus (size_eff),
      .rem     (rem_a)
   );

   bft_mod_lane u_lane_b (
      .clock   (clock),
      .init    (lane_init),
      .step    (cmd.red_step),
      .digit   (prod_ff[ACC_W-1 -: bft_pkg::DIGIT_W]),
      .modulus (size_eff),
      .rem     (rem_b)
   );

   // Bit store: the clearing sweep, then slot a in lookup and slot b in finish.
   assign addr_a      = SLOT_W'(rem_a);
   assign addr_b      = SLOT_W'(rem_b);
   assign clr_addr_in = cmd.clear_en ? clr_addr_ff + SLOT_W'(1) : clr_addr_ff;
   assign status.clear_last = (clr_addr_ff == SLOT_W'(MAX_BITS - 1));

   always_comb begin
      priority if (cmd.clear_en) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = 1'b0;
      end else if (cmd.lookup) begin
         wr_en   = is_insert;
         wr_addr = addr_a;
         wr_data = 1'b1;
      end else begin
         wr_en   = cmd.finish & is_insert;
         wr_addr = addr_b;
         wr_data = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.lookup) begin
         rd_a_ff <= mem[addr_a];
         rd_b_ff <= mem[addr_b];
      end
   end

   // Result register decouples the key stream from the result consumer.
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= bft_pkg::SIZE_RESET;
         sum_ff       <= '0;
         prod_ff      <= ACC_W'(1);
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         sum_ff       <= sum_in;
         prod_ff      <= prod_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      if (cmd.out_load) begin
         op_ff     <= func_ff;
         hit_ff    <= (func_ff == bft_pkg::FUNC_QUERY) & rd_a_ff & rd_b_ff;
         slot_a_ff <= rem_a[bft_pkg::SLOT_OUT_W-1:0];
         slot_b_ff <= rem_b[bft_pkg::SLOT_OUT_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_op_kind   = op_ff;
   assign rsp_may_exist = hit_ff;
   assign rsp_slot_a    = slot_a_ff;
   assign rsp_slot_b    = slot_b_ff;

endmodule
`default_nettype wire

// ----- rtl/bft_ctrl.sv -----
// Controller: sequences clearing, byte intake, reduction, lookup and result hand-off.
`default_nettype none
module bft_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_key_last,
   output logic                        req_stall,
   input  wire bft_pkg::status_type    status,
   output bft_pkg::cmd_type            cmd
);

   bft_pkg::state_type                 state_ff, state_in;
   logic [bft_pkg::RED_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                               accept;
   logic                               red_done;

   assign req_stall = (state_ff != bft_pkg::ST_ACCUM);
   assign accept    = req_valid & ~req_stall;
   assign red_done  = (cnt_ff == bft_pkg::RED_CNT_W'(bft_pkg::RED_STEPS - 1));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.acc_en   = accept;
      unique case (state_ff)
         bft_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = bft_pkg::ST_ACCUM;
            end
         end
         bft_pkg::ST_ACCUM: begin
            cnt_in = '0;
            if (accept & req_key_last) begin
               state_in = bft_pkg::ST_REDUCE;
            end
         end
         bft_pkg::ST_REDUCE: begin
            cmd.red_step = 1'b1;
            cnt_in       = cnt_ff + bft_pkg::RED_CNT_W'(1);
            if (red_done) begin
               state_in = bft_pkg::ST_LOOKUP;
            end
         end
         bft_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = bft_pkg::ST_FINISH;
         end
         bft_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bft_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = bft_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bft_pkg::ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/bloom_filter_two_hash_top.sv -----
// Top level of the two-hash bloom filter over byte-streamed keys.
`default_nettype none
`include "bloom_filter_two_hash_top_macros.svh"
// A key arrives as a run of request words, one key byte each, with the last
// byte flagged by req_key_last; req_func on that last byte selects insert or
// query. While the key streams in, one byte is taken every cycle and folded
// into a running byte sum and a running byte product, both wrapping at 32
// bits. After the last byte the block stalls its input through a reduction
// phase, in which two reduction lanes take both accumulators modulo the
// effective filter size four bits per cycle, a lookup step that reads both
// slots of the bit store (and, for an insert, sets the first), and a finish
// step that sets the second slot and loads the result word. The finish step
// repeats for as long as the previous result word is still waiting to be
// taken. The result word sits in an output register, so the next key can
// stream in while it waits to be taken. After reset the bit store is swept
// clear, one entry a cycle, with the input stalled until the sweep ends;
// the filter size register can be written at any time the block is idle,
// including during the sweep. A filter size of zero acts as one, and a size
// above MAX_BITS acts as MAX_BITS. Slot indices are reported in their low
// seven bits.
module bloom_filter_two_hash_top #(
   parameter int MAX_BITS = bft_pkg::MAX_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [bft_pkg::SIZE_W-1:0]          csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_func,
   input  wire logic [bft_pkg::BYTE_W-1:0]          req_key_byte,
   input  wire logic                                req_key_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_op_kind,
   output logic                                     rsp_may_exist,
   output logic      [bft_pkg::SLOT_OUT_W-1:0]      rsp_slot_a,
   output logic      [bft_pkg::SLOT_OUT_W-1:0]      rsp_slot_b
);

   // Commands flow from the controller to the datapath; status flows back.
   bft_pkg::cmd_type    cmd;
   bft_pkg::status_type status;

   bft_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_key_last (req_key_last),
      .req_stall    (req_stall),
      .status       (status),
      .cmd          (cmd)
   );

   bft_datapath #(
      .MAX_BITS (MAX_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_func         (req_func),
      .req_key_byte     (req_key_byte),
      .req_key_last     (req_key_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_op_kind      (rsp_op_kind),
      .rsp_may_exist    (rsp_may_exist),
      .rsp_slot_a       (rsp_slot_a),
      .rsp_slot_b       (rsp_slot_b)
   );

   // A new result must never overwrite a word the consumer has not taken.
   `BFT_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.out_load, !(rsp_valid && rsp_stall), "result word overwritten while stalled")
   // Loading a result always presents it on the next cycle.
   `BFT_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid, "loaded result not presented")
   // No key byte may be taken while the lanes are reducing, during the lookup or while the store is clearing.
   `BFT_ASSERT_SAME(a_stall_reduce, clock, reset, cmd.red_step || cmd.lookup || cmd.clear_en, req_stall, "input open during reduction, lookup or clearing")
   // Inserts never report a hit.
   `BFT_ASSERT_SAME(a_insert_no_hit, clock, reset, rsp_valid && (rsp_op_kind == bft_pkg::FUNC_INSERT), !rsp_may_exist, "insert result reports a hit")

endmodule
`default_nettype wire
